// ----- hdl/pdl_pkg.sv -----
package pdl_pkg;

	localparam int DATA_W = 32;
	localparam int IDX_W  = 8;
	localparam int CMD_W  = 3;
	localparam int ST_W   = 2;

	// command codes
	localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
	localparam logic [CMD_W-1:0] CMD_INSERT_AT  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_DELETE_AT  = 3'd4;
	localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd5;

	// status codes
	localparam logic [ST_W-1:0] ST_DONE    = 2'd0;
	localparam logic [ST_W-1:0] ST_EMPTY   = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL    = 2'd2;
	localparam logic [ST_W-1:0] ST_INVALID = 2'd3;

	// broadcast to every cell of the chain
	typedef struct packed {
		logic                     ins;
		logic                     rem;
		logic [IDX_W-1:0]         pos;
		logic signed [DATA_W-1:0] val;
	} cell_ctrl_t;

endpackage

// ----- hdl/positional_deque_list.sv -----
// positional deque list: ordered store of signed words in a chain of cells
// output: result word is registered, valid in the cycle after acceptance
// throughput: one command per cycle while results are taken; every cell
//   shifts in the same edge, so insert and delete at any position work alike
// reset: arst_n clears the element count and the output valid; cell contents
//   are left as they are and only read once written
module positional_deque_list #(
	parameter int CAPACITY = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// command side
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // item_value[31:0], item_index[39:32]
	input  logic [2:0]  s_tuser,   // command[2:0]
	// result side
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // result_value[31:0], result_index[39:32],
	                               // element_count[47:40]
	output logic [1:0]  m_tuser    // status[1:0]
);

	localparam int DATA_W = pdl_pkg::DATA_W;
	localparam int IDX_W  = pdl_pkg::IDX_W;
	localparam int OCC_W  = $clog2(CAPACITY + 1);

	// unpack the command word
	logic [pdl_pkg::CMD_W-1:0] command;
	logic signed [DATA_W-1:0]  item_value;
	logic [IDX_W-1:0]          item_index;

	assign command    = s_tuser;
	assign item_value = s_tdata[31:0];
	assign item_index = s_tdata[39:32];

	// handshake: output register frees up when taken, so a new word can
	// enter in the same cycle the previous result leaves
	logic accept;
	logic out_valid_q;

	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	// element count
	logic [OCC_W-1:0] occ_q;
	logic [OCC_W-1:0] occ_d;
	logic [IDX_W-1:0] occ_ext;
	logic             is_full;
	logic             is_empty;

	assign occ_ext  = IDX_W'(occ_q);
	assign is_full  = (occ_q == OCC_W'(CAPACITY));
	assign is_empty = (occ_q == '0);

	// gathered word at the selected position
	logic signed [DATA_W-1:0] taps [CAPACITY];
	logic signed [DATA_W-1:0] picked;

	always_comb begin
		picked = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			picked = picked | taps[i];
		end
	end

	// command decode
	logic [pdl_pkg::ST_W-1:0] status_d;
	logic signed [DATA_W-1:0] rval_d;
	logic [IDX_W-1:0]         pos_d;
	logic [IDX_W-1:0]         rpos_d;
	logic                     do_ins;
	logic                     do_rem;

	always_comb begin
		status_d = pdl_pkg::ST_DONE;
		pos_d    = '0;
		do_ins   = 1'b0;
		do_rem   = 1'b0;
		unique case (command)
			pdl_pkg::CMD_PUSH_FRONT,
			pdl_pkg::CMD_INSERT_AT,
			pdl_pkg::CMD_PUSH_BACK: begin
				if (command == pdl_pkg::CMD_PUSH_BACK) begin
					pos_d = occ_ext;
				end else if (command == pdl_pkg::CMD_INSERT_AT) begin
					// index past the end clamps to the end
					pos_d = (item_index > occ_ext) ? occ_ext : item_index;
				end
				if (is_full) begin
					status_d = pdl_pkg::ST_FULL;
				end else begin
					do_ins = 1'b1;
				end
			end
			pdl_pkg::CMD_POP_FRONT,
			pdl_pkg::CMD_DELETE_AT,
			pdl_pkg::CMD_POP_BACK: begin
				if (command == pdl_pkg::CMD_POP_BACK) begin
					pos_d = occ_ext - IDX_W'(1);
				end else if (command == pdl_pkg::CMD_DELETE_AT) begin
					pos_d = item_index;
				end
				if (is_empty) begin
					status_d = pdl_pkg::ST_EMPTY;
				end else if (pos_d >= occ_ext) begin
					status_d = pdl_pkg::ST_INVALID;
				end else begin
					do_rem = 1'b1;
				end
			end
			default: begin
				status_d = pdl_pkg::ST_INVALID;
			end
		endcase
	end

	always_comb begin
		rval_d = '0;
		rpos_d = '0;
		occ_d  = occ_q;
		if (do_ins) begin
			rval_d = item_value;
			rpos_d = pos_d;
			occ_d  = occ_q + OCC_W'(1);
		end else if (do_rem) begin
			rval_d = picked;
			rpos_d = pos_d;
			occ_d  = occ_q - OCC_W'(1);
		end
	end

	// broadcast to the chain, gated by the handshake
	pdl_pkg::cell_ctrl_t ctrl;

	assign ctrl.ins = accept && do_ins;
	assign ctrl.rem = accept && do_rem;
	assign ctrl.pos = pos_d;
	assign ctrl.val = item_value;

	// chain of cells, each linked to its neighbors below and above
	logic signed [DATA_W-1:0] cell_val [CAPACITY];

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [DATA_W-1:0] prev_v;
		logic signed [DATA_W-1:0] next_v;

		if (i == 0) begin : g_first
			assign prev_v = '0;
		end else begin : g_mid_lo
			assign prev_v = cell_val[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign next_v = '0;
		end else begin : g_mid_hi
			assign next_v = cell_val[i+1];
		end

		pdl_cell #(
			.POS (IDX_W'(i))
		) u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.prev_val (prev_v),
			.next_val (next_v),
			.val      (cell_val[i]),
			.tap      (taps[i])
		);
	end

	// count and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				occ_q <= occ_d;
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result word payload
	logic [pdl_pkg::ST_W-1:0] status_q;
	logic signed [DATA_W-1:0] rval_q;
	logic [IDX_W-1:0]         rpos_q;
	logic [IDX_W-1:0]         count_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_d;
			rval_q   <= rval_d;
			rpos_q   <= rpos_d;
			count_q  <= IDX_W'(occ_d);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = status_q;
	assign m_tdata  = {count_q, rpos_q, rval_q};

`ifndef NO_ASSERTIONS
	// count never exceeds the number of cells
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_W'(CAPACITY))
		else $error("element count above capacity");

	// an insert into a full list is refused and leaves the count alone
	a_full_refused: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_full && (command == pdl_pkg::CMD_PUSH_FRONT ||
		 command == pdl_pkg::CMD_INSERT_AT || command == pdl_pkg::CMD_PUSH_BACK))
		|=> (m_tuser == pdl_pkg::ST_FULL) && $stable(occ_q))
		else $error("insert into full list not refused");

	// a completed removal lowers the count by one
	a_rem_count: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && do_rem) |=> (occ_q == $past(occ_q) - OCC_W'(1)) &&
		(m_tuser == pdl_pkg::ST_DONE))
		else $error("removal count mismatch");
`endif

endmodule

// ----- hdl/pdl_cell.sv -----
module pdl_cell #(
	parameter logic [pdl_pkg::IDX_W-1:0] POS = '0
) (
	input  logic                             clk,
	input  pdl_pkg::cell_ctrl_t              ctrl,
	input  logic signed [pdl_pkg::DATA_W-1:0] prev_val,
	input  logic signed [pdl_pkg::DATA_W-1:0] next_val,
	output logic signed [pdl_pkg::DATA_W-1:0] val,
	output logic signed [pdl_pkg::DATA_W-1:0] tap
);

	logic signed [pdl_pkg::DATA_W-1:0] val_q;

	// insert: own slot takes the new word, cells above shift up
	// remove: own slot and cells above take the neighbor above
	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (POS == ctrl.pos) begin
				val_q <= ctrl.val;
			end else if (POS > ctrl.pos) begin
				val_q <= prev_val;
			end
		end else if (ctrl.rem) begin
			if (POS >= ctrl.pos) begin
				val_q <= next_val;
			end
		end
	end

	assign val = val_q;
	assign tap = (POS == ctrl.pos) ? val_q : '0;

endmodule
